/* design/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define RBA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define RBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rba_pkg.sv */
// Shared types and constants of the reference-counted block allocator.
package rba_pkg;

  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;
  localparam logic [WORD_BITS-1:0] FULL_WORD = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [BIT_W-1:0]     BIT_SEL   = 6'h3F;

  localparam int CMD_W    = 2;
  localparam int HANDLE_W = 8;
  localparam int IDX_W    = 8;
  localparam int REFS_W   = 16;
  localparam int TOTAL_W  = 9;
  localparam int TALLY_W  = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_ADDREF = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic                granted;
    logic [IDX_W-1:0]    block_index;
    logic [REFS_W-1:0]   ref_count;
    logic [TOTAL_W-1:0]  in_use_total;
    logic [TALLY_W-1:0]  alloc_tally;
    logic [TALLY_W-1:0]  free_tally;
    logic [IDX_W-1:0]    hint_index;
  } res_t;

endpackage

/* design/rba_req_if.sv */
// Command channel of the allocator: valid, ready and the request payload.
interface rba_req_if;
  logic                           valid;
  logic                           ready;
  logic [rba_pkg::CMD_W-1:0]      command;
  logic [rba_pkg::HANDLE_W-1:0]   handle;

  modport source (output valid, command, handle, input ready);
  modport sink (input valid, command, handle, output ready);
endinterface

/* design/rba_rsp_if.sv */
// Result channel of the allocator: valid, ready and the result payload.
interface rba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          granted;
  logic [rba_pkg::IDX_W-1:0]     block_index;
  logic [rba_pkg::REFS_W-1:0]    ref_count;
  logic [rba_pkg::TOTAL_W-1:0]   in_use_total;
  logic [rba_pkg::TALLY_W-1:0]   alloc_tally;
  logic [rba_pkg::TALLY_W-1:0]   free_tally;
  logic [rba_pkg::IDX_W-1:0]     hint_index;

  modport source (
    output valid, granted, block_index, ref_count, in_use_total, alloc_tally,
           free_tally, hint_index,
    input  ready
  );
  modport sink (
    input  valid, granted, block_index, ref_count, in_use_total, alloc_tally,
           free_tally, hint_index,
    output ready
  );
endinterface

/* design/rba_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
module rba_ram #(
  parameter int Depth = 256,
  parameter int Width = 16,
  parameter int AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/rba_bitmap.sv */
// Used-block bitmap memory with per-word valid flags that read as zero after reset.
module rba_bitmap #(
  parameter int NumWords = 4,
  parameter int AddrW    = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [AddrW-1:0]                waddr_i,
  input  logic [rba_pkg::WORD_BITS-1:0]   wdata_i,
  input  logic [AddrW-1:0]                raddr_i,
  output logic [rba_pkg::WORD_BITS-1:0]   rdata_o
);

  logic [rba_pkg::WORD_BITS-1:0] mem_q [NumWords];
  logic [NumWords-1:0]           word_vld_q;
  logic [rba_pkg::WORD_BITS-1:0] rdata_q;
  logic                          rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_vld_q <= '0;
    end else if (we_i) begin
      word_vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
    rvld_q  <= word_vld_q[raddr_i];
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

/* design/rba_find.sv */
// First-free-bit finder over one 64-bit bitmap word, byte then bit.
module rba_find (
  input  logic [rba_pkg::WORD_BITS-1:0] word_i,
  output logic                          found_o,
  output logic [rba_pkg::BIT_W-1:0]     bit_o
);

  logic [7:0] byte_free;
  logic [2:0] byte_sel;
  logic [7:0] sel_byte;
  logic [2:0] bit_sel;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      byte_free[j] = ~&word_i[j*8 +: 8];
    end
  end

  always_comb begin
    byte_sel = '0;
    for (int j = 7; j >= 0; j--) begin
      if (byte_free[j]) begin
        byte_sel = 3'(j);
      end
    end
  end

  assign sel_byte = word_i[byte_sel*8 +: 8];

  always_comb begin
    bit_sel = '0;
    for (int j = 7; j >= 0; j--) begin
      if (!sel_byte[j]) begin
        bit_sel = 3'(j);
      end
    end
  end

  assign found_o = (word_i != rba_pkg::FULL_WORD);
  assign bit_o   = {byte_sel, bit_sel};

endmodule

/* design/refcounted_block_allocator.sv */
// Top level of the reference-counted fixed-block allocator.
//
//   channel   dir  handshake            payload
//   req_i     in   req_i.valid/ready    command, handle
//   rsp_o     out  rsp_o.valid/ready    granted, block_index, ref_count, in_use_total,
//                                       alloc_tally, free_tally, hint_index
//
// A command issues the bitmap/refcount read in the transfer cycle and does the update in
// S_LOOK, which loads the result register; a pending result can hold S_LOOK.
// An allocation whose hint word is full scans the bitmap from word 0, one word per cycle
// while no result is pending. The next command transfers the cycle after the result.
// After reset the block is ready at once: per-word valid flags make the bitmap read as empty.
// A result waiting in the output register stalls only the lookup and scan of the following command.
`include "assert_macros.svh"

module refcounted_block_allocator #(
  parameter int NUM_BLOCKS = 256,
  parameter int REF_WIDTH  = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rba_req_if.sink  req_i,
  rba_rsp_if.source rsp_o
);

  localparam int WordBits  = rba_pkg::WORD_BITS;
  localparam int IdxW      = $clog2(NUM_BLOCKS);
  localparam int NumWords  = (NUM_BLOCKS + WordBits - 1) / WordBits;
  localparam int WordAddrW = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int CntW      = $clog2(NUM_BLOCKS + 1);
  localparam int LastBits  = NUM_BLOCKS - (NumWords - 1) * WordBits;
  localparam logic [WordBits-1:0] LastMask =
    (LastBits == WordBits) ? {WordBits{1'b1}} : ((64'd1 << LastBits) - 64'd1);
  localparam int OutIdxW   = rba_pkg::IDX_W;
  localparam int OutRefsW  = rba_pkg::REFS_W;
  localparam int OutTotW   = rba_pkg::TOTAL_W;
  localparam int TallyW    = rba_pkg::TALLY_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  function automatic logic [WordAddrW-1:0] word_of(input logic [IdxW-1:0] idx);
    return WordAddrW'(idx >> rba_pkg::BIT_W);
  endfunction

  function automatic logic [WordBits-1:0] pad_word(input logic [WordBits-1:0] w,
                                                   input logic [WordAddrW-1:0] a);
    return (a == WordAddrW'(NumWords - 1)) ? (w | ~LastMask) : w;
  endfunction

  logic [1:0]              state_q, state_d;
  rba_pkg::cmd_e           cmd_q;
  logic [IdxW-1:0]         h_q;
  logic [OutIdxW-1:0]      hnd_q;
  logic                    in_range_q;
  logic [IdxW-1:0]         hint_q, hint_d;
  logic [CntW-1:0]         in_use_q, in_use_d;
  logic [TallyW-1:0]       alloc_q, alloc_d;
  logic [TallyW-1:0]       free_q, free_d;
  logic [WordAddrW-1:0]    scan_w_q, scan_w_d;
  logic                    out_valid_q, out_valid_d;
  rba_pkg::res_t           res_q, res_d;
  logic                    res_load;

  logic                    accept;
  logic                    can_fin;
  logic [IdxW-1:0]         tgt_in;
  logic [IdxW-1:0]         tgt;
  logic [IdxW-1:0]         pos;

  logic                    bm_we;
  logic [WordAddrW-1:0]    bm_waddr, bm_raddr;
  logic [WordBits-1:0]     bm_wdata, bm_rdata;
  logic                    ref_we;
  logic [IdxW-1:0]         ref_waddr, ref_raddr;
  logic [REF_WIDTH-1:0]    ref_wdata, ref_rdata;

  logic [WordBits-1:0]     find_word;
  logic                    find_ok;
  logic [rba_pkg::BIT_W-1:0] find_bit;
  logic                    used_bit;
  logic [REF_WIDTH-1:0]    refs_cur;
  logic [REF_WIDTH-1:0]    refs_new;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign can_fin     = !out_valid_q || rsp_o.ready;
  assign tgt_in      = (rba_pkg::cmd_e'(req_i.command) == rba_pkg::CMD_ALLOC) ?
                       hint_q : IdxW'(req_i.handle);
  assign tgt         = (cmd_q == rba_pkg::CMD_ALLOC) ? hint_q : h_q;

  rba_bitmap #(
    .NumWords (NumWords),
    .AddrW    (WordAddrW)
  ) u_bitmap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  rba_ram #(
    .Depth (NUM_BLOCKS),
    .Width (REF_WIDTH),
    .AddrW (IdxW)
  ) u_refs (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (ref_waddr),
    .wdata_i (ref_wdata),
    .raddr_i (ref_raddr),
    .rdata_o (ref_rdata)
  );

  assign find_word = (state_q == S_SCAN) ? pad_word(bm_rdata, scan_w_q) :
                                           pad_word(bm_rdata, word_of(tgt));

  rba_find u_find (
    .word_i  (find_word),
    .found_o (find_ok),
    .bit_o   (find_bit)
  );

  assign used_bit = bm_rdata[tgt[rba_pkg::BIT_W-1:0] & rba_pkg::BIT_SEL];
  assign refs_cur = used_bit ? ref_rdata : '0;
  assign refs_new = (refs_cur == {REF_WIDTH{1'b1}}) ? refs_cur : refs_cur + 1'b1;

  always_comb begin
    state_d   = state_q;
    hint_d    = hint_q;
    in_use_d  = in_use_q;
    alloc_d   = alloc_q;
    free_d    = free_q;
    scan_w_d  = scan_w_q;
    res_d     = res_q;
    res_load  = 1'b0;
    pos       = tgt;
    bm_we     = 1'b0;
    bm_waddr  = word_of(tgt);
    bm_wdata  = bm_rdata;
    bm_raddr  = word_of(tgt);
    ref_we    = 1'b0;
    ref_waddr = tgt;
    ref_wdata = '0;
    ref_raddr = tgt;

    case (state_q)
      S_IDLE: begin
        bm_raddr  = word_of(tgt_in);
        ref_raddr = tgt_in;
        if (accept) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (can_fin) begin
          res_d.granted     = 1'b0;
          res_d.block_index = hnd_q;
          res_d.ref_count   = in_range_q ? OutRefsW'(refs_cur) : '0;
          case (cmd_q)
            rba_pkg::CMD_ALLOC: begin
              res_d.block_index = '0;
              res_d.ref_count   = '0;
              if (in_use_q >= CntW'(NUM_BLOCKS)) begin
                res_load = 1'b1;
              end else if (!used_bit || find_ok) begin
                pos      = used_bit ? IdxW'({word_of(tgt), find_bit}) : tgt;
                res_load = 1'b1;
              end else begin
                bm_raddr = '0;
                scan_w_d = '0;
                state_d  = S_SCAN;
              end
            end
            rba_pkg::CMD_ADDREF: begin
              res_load = 1'b1;
              if (in_range_q && used_bit) begin
                ref_we          = 1'b1;
                ref_wdata       = refs_new;
                alloc_d         = alloc_q + 1'b1;
                res_d.granted   = 1'b1;
                res_d.ref_count = OutRefsW'(refs_new);
              end
            end
            rba_pkg::CMD_FREE: begin
              res_load = 1'b1;
              if (in_range_q && used_bit) begin
                ref_we          = 1'b1;
                ref_wdata       = (refs_cur != '0) ? refs_cur - 1'b1 : '0;
                free_d          = free_q + 1'b1;
                res_d.granted   = 1'b1;
                res_d.ref_count = OutRefsW'(ref_wdata);
                if (ref_wdata == '0) begin
                  if (in_use_q != '0) begin
                    in_use_d = in_use_q - 1'b1;
                  end
                  bm_we    = 1'b1;
                  bm_wdata = bm_rdata & ~(64'd1 << (tgt[rba_pkg::BIT_W-1:0]
                                                    & rba_pkg::BIT_SEL));
                  hint_d   = tgt;
                end
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
          if (res_load) begin
            state_d = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        bm_raddr = scan_w_q;
        if (can_fin) begin
          res_d.granted     = 1'b0;
          res_d.block_index = '0;
          res_d.ref_count   = '0;
          if (find_ok) begin
            pos      = IdxW'({scan_w_q, find_bit});
            res_load = 1'b1;
          end else if (scan_w_q == WordAddrW'(NumWords - 1)) begin
            res_load = 1'b1;
          end else begin
            scan_w_d = scan_w_q + 1'b1;
            bm_raddr = scan_w_d;
          end
          if (res_load) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Commit an allocation at pos once the search has settled on it.
    if (res_load && (cmd_q == rba_pkg::CMD_ALLOC) &&
        ((state_q == S_LOOK && in_use_q < CntW'(NUM_BLOCKS)) ||
         (state_q == S_SCAN && find_ok))) begin
      bm_we             = 1'b1;
      bm_waddr          = word_of(pos);
      bm_wdata          = bm_rdata | (64'd1 << (pos[rba_pkg::BIT_W-1:0]
                                                & rba_pkg::BIT_SEL));
      ref_we            = 1'b1;
      ref_waddr         = pos;
      ref_wdata         = REF_WIDTH'(1);
      hint_d            = pos;
      alloc_d           = alloc_q + 1'b1;
      in_use_d          = in_use_q + 1'b1;
      res_d.granted     = 1'b1;
      res_d.block_index = OutIdxW'(pos);
      res_d.ref_count   = OutRefsW'(1);
    end

    if (res_load) begin
      res_d.in_use_total = OutTotW'(in_use_d);
      res_d.alloc_tally  = alloc_d;
      res_d.free_tally   = free_d;
      res_d.hint_index   = OutIdxW'(hint_d);
    end
  end

  assign out_valid_d = res_load || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hint_q      <= '0;
      in_use_q    <= '0;
      alloc_q     <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hint_q      <= hint_d;
      in_use_q    <= in_use_d;
      alloc_q     <= alloc_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= rba_pkg::cmd_e'(req_i.command);
      h_q        <= IdxW'(req_i.handle);
      hnd_q      <= req_i.handle;
      in_range_q <= (32'(req_i.handle) < NUM_BLOCKS);
    end
    scan_w_q <= scan_w_d;
    res_q    <= res_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.granted      = res_q.granted;
  assign rsp_o.block_index  = res_q.block_index;
  assign rsp_o.ref_count    = res_q.ref_count;
  assign rsp_o.in_use_total = res_q.in_use_total;
  assign rsp_o.alloc_tally  = res_q.alloc_tally;
  assign rsp_o.free_tally   = res_q.free_tally;
  assign rsp_o.hint_index   = res_q.hint_index;

  `RBA_ASSERT_SAME(a_no_overwrite, clk_i, rst_ni, res_load, !out_valid_q || rsp_o.ready,
                   "result overwrites a pending transfer")
  `RBA_ASSERT_SAME(a_in_use_bound, clk_i, rst_ni, 1'b1, in_use_q <= CntW'(NUM_BLOCKS),
                   "in-use count above pool size")
  `RBA_ASSERT_NEXT(a_alloc_count, clk_i, rst_ni,
                   res_load && res_d.granted && cmd_q == rba_pkg::CMD_ALLOC,
                   in_use_q == $past(in_use_q) + 1'b1,
                   "granted allocation did not advance in-use count")
  `RBA_ASSERT_NEXT(a_accept_look, clk_i, rst_ni, accept, state_q == S_LOOK,
                   "transfer did not start a lookup")

endmodule

/* test/refcounted_block_allocator_tb.sv */
// Self-checking testbench of the reference-counted block allocator: directed and random commands.
module refcounted_block_allocator_tb;

  localparam int                         NUM_BLOCKS    = 256;
  localparam logic [rba_pkg::REFS_W-1:0] REF_MAX       = '1;
  localparam int                         CYCLE_LIMIT   = 2_000_000;
  localparam int                         SETTLE_CYCLES = 10;
  localparam int                         STACK_REFS    = 40;

  logic clk_i;
  logic rst_ni;

  rba_req_if req_if ();
  rba_rsp_if rsp_if ();

  refcounted_block_allocator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic [NUM_BLOCKS-1:0]          blk_in_use;
  logic [rba_pkg::REFS_W-1:0]     blk_refs [NUM_BLOCKS];
  logic [rba_pkg::TOTAL_W-1:0]    live_total;
  logic [rba_pkg::TALLY_W-1:0]    grant_tally;
  logic [rba_pkg::TALLY_W-1:0]    release_tally;
  logic [rba_pkg::IDX_W-1:0]      hint_blk;

  rba_pkg::res_t pending_results [$];
  int            mismatch_cnt;
  int            cycle_cnt;
  bit            idle_on;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic rba_pkg::res_t apply_command(rba_pkg::cmd_e c,
                                                  logic [rba_pkg::IDX_W-1:0] h);
    rba_pkg::res_t r;
    int   p;
    int   base;
    bit   found;
    r = '0;
    r.block_index = h;
    found = 1'b0;
    p = int'(hint_blk);
    case (c)
      rba_pkg::CMD_ALLOC: begin
        r.block_index = '0;
        if (live_total < NUM_BLOCKS) begin
          if (!blk_in_use[p]) begin
            found = 1'b1;
          end else begin
            base = p & ~(rba_pkg::WORD_BITS - 1);
            for (int b = 0; b < rba_pkg::WORD_BITS && !found; b++) begin
              if (!blk_in_use[base + b]) begin
                p = base + b;
                found = 1'b1;
              end
            end
            for (int i = 0; i < NUM_BLOCKS && !found; i++) begin
              if (!blk_in_use[i]) begin
                p = i;
                found = 1'b1;
              end
            end
          end
          if (found) begin
            hint_blk      = rba_pkg::IDX_W'(p);
            blk_in_use[p] = 1'b1;
            blk_refs[p]   = rba_pkg::REFS_W'(1);
            grant_tally   = grant_tally + 1;
            live_total    = live_total + 1'b1;
            r.granted     = 1'b1;
            r.block_index = rba_pkg::IDX_W'(p);
            r.ref_count   = rba_pkg::REFS_W'(1);
          end
        end
      end
      rba_pkg::CMD_ADDREF: begin
        if (blk_in_use[h]) begin
          if (blk_refs[h] != REF_MAX) blk_refs[h] = blk_refs[h] + 1'b1;
          grant_tally = grant_tally + 1;
          r.granted   = 1'b1;
        end
        r.ref_count = blk_refs[h];
      end
      rba_pkg::CMD_FREE: begin
        if (blk_in_use[h]) begin
          release_tally = release_tally + 1;
          if (blk_refs[h] != 0) blk_refs[h] = blk_refs[h] - 1'b1;
          if (blk_refs[h] == 0) begin
            if (live_total != 0) live_total = live_total - 1'b1;
            blk_in_use[h] = 1'b0;
            hint_blk      = h;
          end
          r.granted = 1'b1;
        end
        r.ref_count = blk_refs[h];
      end
      default: begin
        r.ref_count = blk_refs[h];
      end
    endcase
    r.in_use_total = live_total;
    r.alloc_tally  = grant_tally;
    r.free_tally   = release_tally;
    r.hint_index   = hint_blk;
    return r;
  endfunction

  function automatic logic [rba_pkg::IDX_W-1:0] pick_live_block();
    int start;
    start = $urandom_range(0, NUM_BLOCKS - 1);
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      if (blk_in_use[(start + k) % NUM_BLOCKS]) begin
        return rba_pkg::IDX_W'((start + k) % NUM_BLOCKS);
      end
    end
    return rba_pkg::IDX_W'(start);
  endfunction

  task automatic send_cmd(rba_pkg::cmd_e c, logic [rba_pkg::IDX_W-1:0] h);
    int gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= c;
    req_if.handle  <= h;
    do @(posedge clk_i); while (!req_if.ready);
    pending_results.push_back(apply_command(c, h));
  endtask

  task automatic wait_results_done();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_basic_commands();
    idle_on = 1'b1;
    send_cmd(rba_pkg::CMD_ALLOC, 8'h00);
    send_cmd(rba_pkg::CMD_ALLOC, 8'hFF);
    send_cmd(rba_pkg::CMD_ADDREF, 8'd1);
    send_cmd(rba_pkg::CMD_ADDREF, 8'd5);
    send_cmd(rba_pkg::CMD_FREE, 8'd1);
    send_cmd(rba_pkg::CMD_FREE, 8'd1);
    send_cmd(rba_pkg::CMD_ALLOC, 8'hAA);
    send_cmd(rba_pkg::CMD_FREE, 8'hFF);
    send_cmd(rba_pkg::CMD_NOP, 8'h00);
    send_cmd(rba_pkg::CMD_NOP, 8'hFF);
    send_cmd(rba_pkg::CMD_ADDREF, 8'hFF);
    send_cmd(rba_pkg::CMD_FREE, 8'h00);
    send_cmd(rba_pkg::CMD_FREE, 8'h00);
    send_cmd(rba_pkg::CMD_ALLOC, 8'h55);
    send_cmd(rba_pkg::CMD_FREE, 8'h55);
    send_cmd(rba_pkg::CMD_ADDREF, 8'h00);
    send_cmd(rba_pkg::CMD_NOP, 8'h00);
    wait_results_done();
  endtask

  task automatic test_pool_full();
    int n;
    n = 0;
    while (live_total < NUM_BLOCKS) begin
      idle_on = (n % 64) < 16;
      send_cmd(rba_pkg::CMD_ALLOC, rba_pkg::IDX_W'($urandom_range(0, 255)));
      n++;
    end
    idle_on = 1'b1;
    send_cmd(rba_pkg::CMD_ALLOC, 8'h00);
    send_cmd(rba_pkg::CMD_ALLOC, 8'hFF);
    send_cmd(rba_pkg::CMD_FREE, 8'd130);
    send_cmd(rba_pkg::CMD_ALLOC, 8'h00);
    send_cmd(rba_pkg::CMD_FREE, 8'd5);
    send_cmd(rba_pkg::CMD_FREE, 8'd200);
    send_cmd(rba_pkg::CMD_ALLOC, 8'h00);
    send_cmd(rba_pkg::CMD_ALLOC, 8'h00);
    send_cmd(rba_pkg::CMD_FREE, 8'd70);
    send_cmd(rba_pkg::CMD_FREE, 8'd100);
    send_cmd(rba_pkg::CMD_ALLOC, 8'h00);
    send_cmd(rba_pkg::CMD_ALLOC, 8'h00);
    send_cmd(rba_pkg::CMD_ALLOC, 8'h00);
  endtask

  task automatic test_drain_pool();
    idle_on = 1'b0;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      while (blk_in_use[i]) send_cmd(rba_pkg::CMD_FREE, rba_pkg::IDX_W'(i));
    end
    idle_on = 1'b1;
    send_cmd(rba_pkg::CMD_ALLOC, 8'h00);
    send_cmd(rba_pkg::CMD_ALLOC, 8'h00);
  endtask

  task automatic test_random_traffic();
    int roll;
    int alloc_pct;
    for (int seg = 0; seg < 10; seg++) begin
      idle_on   = (seg % 3) != 2;
      alloc_pct = (seg % 2 == 0) ? 50 : 15;
      if (seg == 5) wait_results_done();
      repeat (90) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          send_cmd(rba_pkg::cmd_e'($urandom_range(0, 3)),
                   rba_pkg::IDX_W'($urandom_range(0, 255)));
        end else if (roll < 10 + alloc_pct) begin
          send_cmd(rba_pkg::CMD_ALLOC, rba_pkg::IDX_W'($urandom_range(0, 255)));
        end else if (roll < 25 + alloc_pct) begin
          send_cmd(rba_pkg::CMD_ADDREF, pick_live_block());
        end else begin
          send_cmd(rba_pkg::CMD_FREE, pick_live_block());
        end
      end
    end
  endtask

  task automatic test_refcount_stack();
    logic [rba_pkg::IDX_W-1:0] blk;
    idle_on = 1'b0;
    while (live_total == NUM_BLOCKS) send_cmd(rba_pkg::CMD_FREE, pick_live_block());
    send_cmd(rba_pkg::CMD_ALLOC, 8'h00);
    blk = hint_blk;
    repeat (STACK_REFS) send_cmd(rba_pkg::CMD_ADDREF, blk);
    idle_on = 1'b1;
    send_cmd(rba_pkg::CMD_FREE, blk);
    send_cmd(rba_pkg::CMD_FREE, blk);
    send_cmd(rba_pkg::CMD_ADDREF, blk);
    send_cmd(rba_pkg::CMD_NOP, blk);
  endtask

  initial begin
    int stall;
    forever begin
      stall = idle_on ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rst_ni));
    end
  end

  always @(posedge clk_i) begin
    rba_pkg::res_t got;
    rba_pkg::res_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.granted      = rsp_if.granted;
      got.block_index  = rsp_if.block_index;
      got.ref_count    = rsp_if.ref_count;
      got.in_use_total = rsp_if.in_use_total;
      got.alloc_tally  = rsp_if.alloc_tally;
      got.free_tally   = rsp_if.free_tally;
      got.hint_index   = rsp_if.hint_index;
      if (pending_results.size() == 0) begin
        if (mismatch_cnt < 10) $display("unexpected result at cycle %0d", cycle_cnt);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatch_cnt < 10) begin
            $display("mismatch at cycle %0d: expected g=%0d idx=%0d refs=%0d used=%0d",
                     cycle_cnt, want.granted, want.block_index, want.ref_count,
                     want.in_use_total);
            $display("  alloc=%0d free=%0d hint=%0d; got g=%0d idx=%0d refs=%0d used=%0d",
                     want.alloc_tally, want.free_tally, want.hint_index, got.granted,
                     got.block_index, got.ref_count, got.in_use_total);
            $display("  alloc=%0d free=%0d hint=%0d",
                     got.alloc_tally, got.free_tally, got.hint_index);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.command <= rba_pkg::CMD_ALLOC;
    req_if.handle  <= '0;
    idle_on        = 1'b0;
    mismatch_cnt   = 0;
    cycle_cnt      = 0;
    blk_in_use     = '0;
    for (int i = 0; i < NUM_BLOCKS; i++) blk_refs[i] = '0;
    live_total     = '0;
    grant_tally    = '0;
    release_tally  = '0;
    hint_blk       = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic_commands();
    test_pool_full();
    test_drain_pool();
    test_random_traffic();
    test_refcount_stack();
    wait_results_done();
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
